FILE: hw/rtl/fwbt_pkg.sv
// Package for the four-way bound table store: request/result structs, command codes,
// flag bits, entry layout and sizing defaults.
// No dependencies.
package fwbt_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 65536;
    localparam int unsigned MAXAGE_DEF        = 256;
    localparam int unsigned MAXDEPTH_DEF      = 256;

    typedef enum logic [2:0] {
        CMD_LOWER_ALL = 3'd0,
        CMD_UPPER_CUT = 3'd1,
        CMD_LOWER     = 3'd2,
        CMD_UPPER     = 3'd3,
        CMD_EXACT     = 3'd4,
        CMD_AGE       = 3'd5,
        CMD_RSVD6     = 3'd6,
        CMD_RSVD7     = 3'd7
    } t_cmd;

    localparam logic [7:0] F_LOWER = 8'h01;
    localparam logic [7:0] F_UPPER = 8'h02;
    localparam logic [7:0] F_CUT   = 8'h04;
    localparam logic [7:0] F_ALL   = 8'h08;
    localparam logic [7:0] F_EXACT = 8'h10;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [63:0] position_key;
        logic [14:0] best_move;
        logic [7:0]  search_depth;
        logic signed [15:0] score;
        logic [7:0]  exact_flags;
    } t_req;

    typedef struct packed {
        logic [1:0] way_written;
        logic       tag_matched;
        logic [3:0] ways_cleared;
    } t_rsp;

    // one table entry as held in memory
    typedef struct packed {
        logic [31:0] tag;
        logic [7:0]  dhi;
        logic [7:0]  dlo;
        logic [14:0] mv;
        logic [15:0] vhi;
        logic [15:0] vlo;
        logic [7:0]  age;
        logic [7:0]  flags;
    } t_entry;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DECIDE,
        ST_WRITE
    } t_state;

endpackage

FILE: hw/rtl/four_way_bound_table_store.sv
// Top level of the four-way bound table store: bucket memory, clearing sweep,
// read-decide-write sequencer. Depends on fwbt_pkg.
//
// A request (start high while busy low) stores one bound into a four-way bucket or
// advances the search age. The four ways of a bucket sit side by side in one memory
// word, so a store runs through a read state, a decide state and a write state: busy
// is high in those states and o_done is high in the cycle after the write. A new
// request can be accepted in the strobe cycle, but not while a store is under way.
// An age advance or unused command keeps busy low and strobes in the cycle after
// acceptance. The result is on o_rsp in the o_done cycle; the receiver cannot stall
// it. After reset the block runs a clearing pass over all TABLE_ENTRIES/4 buckets,
// one bucket per cycle, with busy high throughout.
module four_way_bound_table_store
    import fwbt_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int unsigned MAXAGE        = MAXAGE_DEF,
    parameter int unsigned MAXDEPTH      = MAXDEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_done,
    output t_rsp o_rsp
);

    localparam int unsigned NB = TABLE_ENTRIES / 4;
    localparam int unsigned AW = (NB > 1) ? $clog2(NB) : 1;
    localparam int unsigned SW = 18; // age*MAXDEPTH+MAXDEPTH fits in 17 bits
    localparam logic [7:0] HALF_AGE = 8'(MAXAGE / 2);
    localparam logic [7:0] AGE_LAST = 8'(MAXAGE - 1);
    localparam logic [7:0] AGE_MASK = 8'(MAXAGE - 1);

    // bucket memory: four entries per word
    t_entry [3:0] r_mem [NB];
    t_entry [3:0] r_rd;
    logic   [AW-1:0] mem_addr;
    logic   mem_we;
    t_entry [3:0] mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wd;
        end
        r_rd <= r_mem[mem_addr];
    end

    t_state r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [7:0] r_age, n_age;
    t_req r_req;
    t_entry [3:0] r_new, n_new;
    t_rsp r_res, n_res;
    logic r_done, n_done;

    wire [AW-1:0] bucket = AW'(r_req.position_key[AW+1:2]);
    wire [31:0] tag = r_req.position_key[63:32];
    wire [7:0] dep = r_req.search_depth;

    // clear value for one entry
    function automatic t_entry blank(input logic [7:0] age);
        t_entry e;
        e = '0;
        e.age = age;
        return e;
    endfunction

    // next state
    always_comb begin
        n_state = r_state;
        n_clr = r_clr;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == AW'(NB - 1)) n_state = ST_IDLE;
            end
            ST_IDLE:   if (start && i_req.cmd <= CMD_EXACT) n_state = ST_READ;
            ST_READ:   n_state = ST_DECIDE;
            ST_DECIDE: n_state = ST_WRITE;
            ST_WRITE:  n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // decide: match, replacement, exact-store clears
    always_comb begin
        logic hit;
        logic [1:0] hw, rw;
        logic [SW-1:0] best, s;
        logic [7:0] dl, du, f, dmax, ad;
        logic ok;
        t_entry e;
        hit = 1'b0; hw = '0; rw = '0; best = '0;
        s = '0; ad = '0; ok = 1'b0; e = '0;
        n_new = r_rd;
        n_res = '0;
        for (int i = 0; i < 4; i++) begin
            dl = r_rd[i].dlo; du = r_rd[i].dhi; f = r_rd[i].flags;
            dmax = (dl > du) ? dl : du;
            case (t_cmd'(r_req.cmd))
                CMD_LOWER_ALL: ok = (dl == 0 || (f & F_ALL) != 0) && dl <= dep;
                CMD_UPPER_CUT: ok = (du == 0 || (f & F_CUT) != 0) && du <= dep;
                CMD_LOWER:     ok = (f & F_EXACT) == 0 && dl <= dep;
                CMD_UPPER:     ok = (f & F_EXACT) == 0 && du <= dep;
                default:       ok = dmax <= dep;
            endcase
            if (!hit) begin
                if (r_rd[i].tag == tag && ok) begin
                    hit = 1'b1; hw = 2'(i);
                end else begin
                    ad = (r_age - r_rd[i].age) & AGE_MASK;
                    s = SW'(ad) * SW'(MAXDEPTH) + SW'(MAXDEPTH) - SW'(dmax) - SW'(1);
                    if (s > best) begin best = s; rw = 2'(i); end
                end
            end
        end
        if (hit) begin
            e = r_rd[hw];
            f = e.flags;
            case (t_cmd'(r_req.cmd)) inside
                CMD_LOWER_ALL, CMD_LOWER: begin
                    e.dlo = dep; e.mv = r_req.best_move; e.vlo = r_req.score;
                    f = f | F_LOWER;
                    f = (r_req.cmd == CMD_LOWER_ALL) ? (f | F_ALL) : (f & ~F_ALL);
                    e.flags = f; e.age = r_age;
                end
                CMD_UPPER_CUT, CMD_UPPER: begin
                    e.dhi = dep; e.vhi = r_req.score;
                    f = f | F_UPPER;
                    f = (r_req.cmd == CMD_UPPER_CUT) ? (f | F_CUT) : (f & ~F_CUT);
                    e.flags = f; e.age = r_age;
                end
                default: begin
                    e.dlo = dep; e.dhi = dep; e.mv = r_req.best_move;
                    e.vlo = r_req.score; e.vhi = r_req.score;
                    e.flags = r_req.exact_flags; e.age = r_age;
                end
            endcase
            n_new[hw] = e;
            n_res.way_written = hw;
            n_res.tag_matched = 1'b1;
            if (r_req.cmd == CMD_EXACT) begin
                for (int j = 1; j < 4; j++) begin
                    dl = r_rd[j].dlo; du = r_rd[j].dhi;
                    dmax = (dl > du) ? dl : du;
                    if (2'(j) > hw && r_rd[j].tag == tag && dmax <= dep) begin
                        n_new[j] = blank(r_age ^ HALF_AGE);
                        n_res.ways_cleared[j] = 1'b1;
                    end
                end
            end
        end else begin
            e = '0;
            e.tag = tag; e.age = r_age;
            case (t_cmd'(r_req.cmd)) inside
                CMD_LOWER_ALL, CMD_LOWER: begin
                    e.dlo = dep; e.mv = r_req.best_move; e.vlo = r_req.score;
                    e.flags = (r_req.cmd == CMD_LOWER_ALL) ? (F_LOWER | F_ALL) : F_LOWER;
                end
                CMD_UPPER_CUT, CMD_UPPER: begin
                    e.dhi = dep; e.vhi = r_req.score;
                    e.flags = (r_req.cmd == CMD_UPPER_CUT) ? (F_UPPER | F_CUT) : F_UPPER;
                end
                default: begin
                    e.dlo = dep; e.dhi = dep; e.mv = r_req.best_move;
                    e.vlo = r_req.score; e.vhi = r_req.score;
                    e.flags = r_req.exact_flags;
                end
            endcase
            n_new[rw] = e;
            n_res.way_written = rw;
        end
    end

    // outputs and memory control
    always_comb begin
        mem_we = 1'b0;
        mem_addr = bucket;
        mem_wd = r_new;
        n_age = r_age;
        n_done = 1'b0;
        busy = 1'b1;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_addr = r_clr;
                mem_wd = {4{blank(HALF_AGE)}};
            end
            ST_IDLE: begin
                busy = 1'b0;
                if (start && i_req.cmd > CMD_EXACT) begin
                    n_done = 1'b1;
                    if (i_req.cmd == CMD_AGE) n_age = (r_age == AGE_LAST) ? 8'd0 : r_age + 8'd1;
                end
            end
            ST_READ:   ;
            ST_DECIDE: ;
            ST_WRITE: begin
                mem_we = 1'b1;
                n_done = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr <= '0;
            r_age <= '0;
            r_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_age <= n_age;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && start) r_req <= i_req;
        if (r_state == ST_DECIDE) begin
            r_new <= n_new;
            r_res <= n_res;
        end else if (r_state == ST_IDLE) begin
            r_res <= '0;
        end
    end

    assign o_done = r_done;
    assign o_rsp = r_res;

    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_WRITE && !(r_state == ST_IDLE && start)) |=> !r_done)
        else $error("result strobe without a request");
    a_write_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE) |=> r_done) else $error("store finished without result");
    a_clr_ways: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && o_rsp.ways_cleared != 4'd0 |-> o_rsp.tag_matched)
        else $error("ways cleared without in-place update");
    a_clr_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> o_rsp.ways_cleared[0] == 1'b0) else $error("way 0 cleared");

endmodule
